// File: rtl/njs_pkg.sv
// types, codes and helpers shared by the nearest joint solution selector
package njs_pkg;

  localparam int JOINT_FIELDS = 7;
  localparam int LANES        = 8;
  localparam int QUEUE_DEPTH  = 8;

  localparam logic [1:0] FUNC_REF  = 2'd0;
  localparam logic [1:0] FUNC_CAND = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;

  typedef logic signed [15:0] angle_t;
  typedef logic [15:0]        mag_t;
  typedef logic [31:0]        square_t;
  typedef logic [32:0]        pair_t;
  typedef logic [35:0]        dist_t;
  typedef logic [34:0]        tol_t;

  localparam tol_t  TOL_RESET = 35'd1678;
  localparam dist_t DIST_MAX  = '1;
  localparam mag_t  PHI_MAX   = '1;

  typedef struct packed {
    logic [1:0] func;
    angle_t     joint_0;
    angle_t     joint_1;
    angle_t     joint_2;
    angle_t     joint_3;
    angle_t     joint_4;
    angle_t     joint_5;
    angle_t     joint_6;
    angle_t     phi;
    logic       last;
  } cand_t;

  typedef struct packed {
    logic   found;
    angle_t best_joint_0;
    angle_t best_joint_1;
    angle_t best_joint_2;
    angle_t best_joint_3;
    angle_t best_joint_4;
    angle_t best_joint_5;
    angle_t best_joint_6;
    angle_t best_phi;
  } result_t;

  typedef angle_t [JOINT_FIELDS-1:0] joint_vec_t;

  typedef enum logic {
    OP_CAND,
    OP_END
  } op_t;

  // one classified item waiting between front and back
  typedef struct packed {
    op_t        op;
    logic       last;
    joint_vec_t joints;
    angle_t     phi;
    dist_t      sqdist;
  } entry_t;

  function automatic joint_vec_t unpack_joints(cand_t c);
    joint_vec_t v;
    v[0] = c.joint_0;
    v[1] = c.joint_1;
    v[2] = c.joint_2;
    v[3] = c.joint_3;
    v[4] = c.joint_4;
    v[5] = c.joint_5;
    v[6] = c.joint_6;
    return v;
  endfunction

  function automatic result_t pack_result(logic found, joint_vec_t j, angle_t phi);
    result_t r;
    r.found        = found;
    r.best_joint_0 = j[0];
    r.best_joint_1 = j[1];
    r.best_joint_2 = j[2];
    r.best_joint_3 = j[3];
    r.best_joint_4 = j[4];
    r.best_joint_5 = j[5];
    r.best_joint_6 = j[6];
    r.best_phi     = phi;
    return r;
  endfunction

  function automatic mag_t magnitude(angle_t a);
    return a[15] ? mag_t'(-a) : mag_t'(a);
  endfunction

endpackage

// File: rtl/nearest_joint_solution_phi_tiebreak.sv
// nearest joint solution selector with arm-angle tie-break, top level
// an accepted item passes the four distance stages and the queue before its result is registered
// throughput: one item per cycle while cand_stall is low; four distance stages feed an eight-entry queue
// cand_stall rises when queue plus distance stages hold eight items
// reset (rst, synchronous): reference and search state cleared, tolerance back to 1678
module nearest_joint_solution_phi_tiebreak #(
  parameter int JOINT_COUNT = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cand_valid,
  output logic             cand_stall,
  input  njs_pkg::cand_t   cand,
  output logic             result_valid,
  input  logic             result_stall,
  output njs_pkg::result_t result,
  input  logic             tol_we,
  input  njs_pkg::tol_t    tol_data
);

  localparam int UsedJoints = (JOINT_COUNT < njs_pkg::JOINT_FIELDS) ? JOINT_COUNT
                                                                    : njs_pkg::JOINT_FIELDS;
  localparam int CountBits  = $clog2(njs_pkg::QUEUE_DEPTH+1);

  logic                 accept;
  logic                 push;
  njs_pkg::entry_t      push_entry;
  logic [2:0]           inflight;
  logic                 pop;
  njs_pkg::entry_t      head;
  logic                 head_valid;
  logic [CountBits-1:0] count;
  logic [CountBits:0]   held;

  // every item in the distance stages has a queue slot reserved
  assign held       = (CountBits+1)'(count) + (CountBits+1)'(inflight);
  assign cand_stall = held >= (CountBits+1)'(njs_pkg::QUEUE_DEPTH);
  assign accept     = cand_valid && !cand_stall;

  njs_front #(
    .UsedJoints (UsedJoints)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cand       (cand),
    .push       (push),
    .push_entry (push_entry),
    .inflight   (inflight)
  );

  njs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (count)
  );

  njs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tol_we       (tol_we),
    .tol_data     (tol_data),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/njs_front.sv
// front end: takes items, holds the reference, computes squared distance in four stages
module njs_front #(
  parameter int UsedJoints = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  njs_pkg::cand_t  cand,
  output logic            push,
  output njs_pkg::entry_t push_entry,
  output logic [2:0]      inflight
);

  njs_pkg::angle_t  ref_joints [njs_pkg::JOINT_FIELDS];
  njs_pkg::joint_vec_t in_joints;
  logic             in_push;
  njs_pkg::mag_t    in_mag [njs_pkg::LANES];

  logic             v1, v2, v3, v4;
  njs_pkg::entry_t  e1, e2, e3, e4;
  njs_pkg::mag_t    mag1 [njs_pkg::LANES];
  njs_pkg::square_t sq2 [njs_pkg::LANES];
  njs_pkg::pair_t   pair3 [njs_pkg::LANES/2];

  always_comb begin
    njs_pkg::joint_vec_t raw;
    logic signed [16:0]  d;
    raw = njs_pkg::unpack_joints(cand);
    for (int i = 0; i < njs_pkg::JOINT_FIELDS; i++) begin
      in_joints[i] = (i < UsedJoints) ? raw[i] : '0;
    end
    for (int i = 0; i < njs_pkg::LANES; i++) begin
      in_mag[i] = '0;
    end
    for (int i = 0; i < njs_pkg::JOINT_FIELDS; i++) begin
      d = '0;
      if (i < UsedJoints) begin
        d = {in_joints[i][15], in_joints[i]} - {ref_joints[i][15], ref_joints[i]};
        in_mag[i] = d[16] ? 16'(-d) : d[15:0];
      end
    end
    in_push = accept && (cand.func == njs_pkg::FUNC_CAND || cand.func == njs_pkg::FUNC_END);
  end

  // reference is taken at acceptance, so items already in the stages keep the old one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < njs_pkg::JOINT_FIELDS; i++) begin
        ref_joints[i] <= '0;
      end
    end else if (accept && cand.func == njs_pkg::FUNC_REF) begin
      for (int i = 0; i < njs_pkg::JOINT_FIELDS; i++) begin
        ref_joints[i] <= in_joints[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    e1.op     <= (cand.func == njs_pkg::FUNC_END) ? njs_pkg::OP_END : njs_pkg::OP_CAND;
    e1.last   <= cand.last;
    e1.joints <= in_joints;
    e1.phi    <= cand.phi;
    e1.sqdist <= '0;
    for (int i = 0; i < njs_pkg::LANES; i++) begin
      mag1[i] <= in_mag[i];
    end
    e2 <= e1;
    for (int i = 0; i < njs_pkg::LANES; i++) begin
      sq2[i] <= njs_pkg::square_t'(mag1[i]) * njs_pkg::square_t'(mag1[i]);
    end
    e3 <= e2;
    for (int k = 0; k < njs_pkg::LANES/2; k++) begin
      pair3[k] <= njs_pkg::pair_t'(sq2[2*k]) + njs_pkg::pair_t'(sq2[2*k+1]);
    end
    e4.op     <= e3.op;
    e4.last   <= e3.last;
    e4.joints <= e3.joints;
    e4.phi    <= e3.phi;
    e4.sqdist <= (njs_pkg::dist_t'(pair3[0]) + njs_pkg::dist_t'(pair3[1]))
               + (njs_pkg::dist_t'(pair3[2]) + njs_pkg::dist_t'(pair3[3]));
  end

  assign push       = v4;
  assign push_entry = e4;
  assign inflight   = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4);

endmodule

// File: rtl/njs_queue.sv
// short queue of classified items between front and back
module njs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  njs_pkg::entry_t push_entry,
  input  logic            pop,
  output njs_pkg::entry_t head,
  output logic            head_valid,
  output logic [$clog2(njs_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int PtrBits   = $clog2(njs_pkg::QUEUE_DEPTH);
  localparam int CountBits = $clog2(njs_pkg::QUEUE_DEPTH+1);

  njs_pkg::entry_t      entries [njs_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrBits'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CountBits'(1);
        2'b01:   count <= count - CountBits'(1);
        default: count <= count;
      endcase
    end
  end

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);

endmodule

// File: rtl/njs_back.sv
// back end: running best with tie band and phi tie-break, result register
module njs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             tol_we,
  input  njs_pkg::tol_t    tol_data,
  input  njs_pkg::entry_t  head,
  input  logic             head_valid,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output njs_pkg::result_t result
);

  njs_pkg::tol_t       tol;
  njs_pkg::dist_t      least_distance;
  njs_pkg::mag_t       least_phi;
  logic                have_candidate;
  njs_pkg::joint_vec_t kept_joints;
  njs_pkg::angle_t     kept_phi;

  njs_pkg::dist_t      gap;
  njs_pkg::mag_t       phimag;
  logic                tie;
  logic                take;
  logic                new_dist;
  logic                emit;
  njs_pkg::joint_vec_t kept_joints_next;
  njs_pkg::angle_t     kept_phi_next;

  always_comb begin
    gap      = (head.sqdist > least_distance) ? head.sqdist - least_distance
                                              : least_distance - head.sqdist;
    phimag   = njs_pkg::magnitude(head.phi);
    tie      = gap <= {1'b0, tol};
    new_dist = !have_candidate || (!tie && head.sqdist < least_distance);
    take     = new_dist || (have_candidate && tie && phimag < least_phi);
    emit     = (head.op == njs_pkg::OP_END) || head.last;
    pop      = head_valid && (!result_valid || !result_stall);
    kept_joints_next = take ? head.joints : kept_joints;
    kept_phi_next    = take ? head.phi : kept_phi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol            <= njs_pkg::TOL_RESET;
      least_distance <= njs_pkg::DIST_MAX;
      least_phi      <= njs_pkg::PHI_MAX;
      have_candidate <= 1'b0;
      kept_joints    <= '0;
      kept_phi       <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (tol_we) begin
        tol <= tol_data;
      end
      if (pop) begin
        if (emit) begin
          least_distance <= njs_pkg::DIST_MAX;
          least_phi      <= njs_pkg::PHI_MAX;
          have_candidate <= 1'b0;
          kept_joints    <= '0;
          kept_phi       <= '0;
        end else if (take) begin
          if (new_dist) begin
            least_distance <= head.sqdist;
          end
          least_phi      <= phimag;
          have_candidate <= 1'b1;
          kept_joints    <= head.joints;
          kept_phi       <= head.phi;
        end
      end
      if (pop && emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      if (head.op == njs_pkg::OP_END) begin
        result <= '0;
      end else begin
        result <= njs_pkg::pack_result(1'b1, kept_joints_next, kept_phi_next);
      end
    end
  end

endmodule

// File: rtl/njs_checker.sv
// port checks for the nearest joint solution selector, bound to the top level
module njs_checker (
  input logic             clk,
  input logic             rst,
  input logic             cand_valid,
  input logic             cand_stall,
  input njs_pkg::cand_t   cand,
  input logic             result_valid,
  input logic             result_stall,
  input njs_pkg::result_t result
);

  // a held result keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // an empty search reports all zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      result.best_joint_0 == '0 && result.best_joint_1 == '0 &&
      result.best_joint_2 == '0 && result.best_joint_3 == '0 &&
      result.best_joint_4 == '0 && result.best_joint_5 == '0 &&
      result.best_joint_6 == '0 && result.best_phi == '0)
    else $error("empty search result not zero");

  // nothing is reported straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // no result can appear without an item having gone in some cycles before
  a_no_early: assert property (@(posedge clk)
    rst |=> !result_valid ##1 !result_valid)
    else $error("result too soon after reset");

endmodule

bind nearest_joint_solution_phi_tiebreak njs_checker u_njs_checker (.*);

// File: tb/sv/njs_result_checker.sv
// checker for the nearest joint solution selector: predicts each winner and compares it
module njs_result_checker #(
  parameter int JOINT_COUNT = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cand_valid,
  input  logic             cand_stall,
  input  njs_pkg::cand_t   cand,
  input  logic             result_valid,
  input  logic             result_stall,
  input  njs_pkg::result_t result,
  input  logic             tol_we,
  input  njs_pkg::tol_t    tol_data,
  output int               errors,
  output int               open_count
);

  njs_pkg::joint_vec_t target_joints;
  njs_pkg::joint_vec_t kept_joints;
  njs_pkg::angle_t     kept_phi;
  njs_pkg::dist_t      best_dist;
  njs_pkg::mag_t       best_mag;
  logic                have_best;
  njs_pkg::tol_t       tolerance;
  njs_pkg::result_t    winners_due [$];

  function automatic void drop_search();
    kept_joints = '0;
    kept_phi    = '0;
    best_dist   = njs_pkg::DIST_MAX;
    best_mag    = njs_pkg::PHI_MAX;
    have_best   = 1'b0;
  endfunction

  always @(posedge clk) begin
    njs_pkg::joint_vec_t                       cj;
    njs_pkg::angle_t                           phi;
    njs_pkg::angle_t [njs_pkg::LANES-1:0]      got_v;
    njs_pkg::angle_t [njs_pkg::LANES-1:0]      want_v;
    njs_pkg::mag_t                             phi_mag;
    longint                                    diff;
    longint                                    sq_sum;
    longint                                    gap;
    logic                                      take;
    logic                                      new_dist;
    njs_pkg::result_t                          want;
    string                                     fname;
    if (rst) begin
      target_joints = '0;
      tolerance     = njs_pkg::TOL_RESET;
      drop_search();
      winners_due.delete();
    end else begin
      if (tol_we) begin
        tolerance = tol_data;
      end
      if (cand_valid && !cand_stall) begin
        cj  = {cand.joint_6, cand.joint_5, cand.joint_4, cand.joint_3,
               cand.joint_2, cand.joint_1, cand.joint_0};
        phi = cand.phi;
        case (cand.func)
          njs_pkg::FUNC_REF: begin
            for (int i = 0; i < JOINT_COUNT; i++) target_joints[i] = cj[i];
          end
          njs_pkg::FUNC_END: begin
            // empty search: all-zero item, any pending candidates discarded
            drop_search();
            want = '0;
            winners_due.insert(winners_due.size(), want);
          end
          njs_pkg::FUNC_CAND: begin
            sq_sum = 0;
            for (int i = 0; i < JOINT_COUNT; i++) begin
              diff   = longint'($signed(cj[i])) - longint'($signed(target_joints[i]));
              sq_sum = sq_sum + diff * diff;
            end
            if (sq_sum > longint'(njs_pkg::DIST_MAX)) sq_sum = longint'(njs_pkg::DIST_MAX);
            phi_mag  = njs_pkg::mag_t'(phi[15] ? -longint'($signed(phi))
                                               : longint'($signed(phi)));
            take     = !have_best;
            new_dist = !have_best;
            if (have_best) begin
              gap = sq_sum - longint'(best_dist);
              if (gap < 0) gap = -gap;
              // inside the tie band only a smaller |phi| wins, and the distance stays
              if (gap <= longint'(tolerance)) begin
                take = (phi_mag < best_mag);
              end else if (sq_sum < longint'(best_dist)) begin
                take     = 1'b1;
                new_dist = 1'b1;
              end
            end
            if (take) begin
              kept_joints = '0;
              for (int i = 0; i < JOINT_COUNT; i++) kept_joints[i] = cj[i];
              kept_phi  = phi;
              best_mag  = phi_mag;
              have_best = 1'b1;
              if (new_dist) best_dist = njs_pkg::dist_t'(sq_sum);
            end
            if (cand.last) begin
              want.found        = 1'b1;
              want.best_joint_0 = kept_joints[0];
              want.best_joint_1 = kept_joints[1];
              want.best_joint_2 = kept_joints[2];
              want.best_joint_3 = kept_joints[3];
              want.best_joint_4 = kept_joints[4];
              want.best_joint_5 = kept_joints[5];
              want.best_joint_6 = kept_joints[6];
              want.best_phi     = kept_phi;
              winners_due.insert(winners_due.size(), want);
              drop_search();
            end
          end
          default: begin
          end
        endcase
      end
      if (result_valid && !result_stall) begin
        if (winners_due.size() == 0) begin
          $error("result item arrived with none due");
          errors++;
        end else begin
          want = winners_due.pop_front();
          if (result.found !== want.found) begin
            $error("found expected %0d got %0d", want.found, result.found);
            errors++;
          end
          got_v  = {result.best_phi, result.best_joint_6, result.best_joint_5,
                    result.best_joint_4, result.best_joint_3, result.best_joint_2,
                    result.best_joint_1, result.best_joint_0};
          want_v = {want.best_phi, want.best_joint_6, want.best_joint_5,
                    want.best_joint_4, want.best_joint_3, want.best_joint_2,
                    want.best_joint_1, want.best_joint_0};
          for (int i = 0; i < njs_pkg::LANES; i++) begin
            if (got_v[i] !== want_v[i]) begin
              fname = (i < njs_pkg::JOINT_FIELDS) ? $sformatf("best_joint_%0d", i)
                                                  : "best_phi";
              $error("%s expected %0d got %0d", fname, $signed(want_v[i]),
                     $signed(got_v[i]));
              errors++;
            end
          end
        end
      end
    end
    open_count <= winners_due.size();
  end

endmodule

// File: tb/sv/tb_nearest_joint_solution_phi_tiebreak.sv
// testbench top for the nearest joint solution selector: stimulus, result hold-offs, verdict
module tb_nearest_joint_solution_phi_tiebreak;

  localparam int              JOINT_COUNT = 7;
  localparam logic [1:0]      FUNC_UNUSED = 2'd3;
  localparam njs_pkg::angle_t ANGLE_MAX   = 16'sh7fff;
  localparam njs_pkg::angle_t ANGLE_MIN   = 16'sh8000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cand_valid   = 1'b0;
  logic                cand_stall;
  njs_pkg::cand_t      cand         = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  njs_pkg::result_t    result;
  logic                tol_we       = 1'b0;
  njs_pkg::tol_t       tol_data     = '0;
  int                  errors;
  int                  open_count;

  logic                calm         = 1'b0;
  logic                hold_armed   = 1'b0;
  logic                hold_done    = 1'b0;
  int                  hold_left    = 0;
  int                  items_sent   = 0;
  njs_pkg::joint_vec_t home         = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  nearest_joint_solution_phi_tiebreak #(
    .JOINT_COUNT (JOINT_COUNT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cand_valid   (cand_valid),
    .cand_stall   (cand_stall),
    .cand         (cand),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .tol_we       (tol_we),
    .tol_data     (tol_data)
  );

  njs_result_checker #(
    .JOINT_COUNT (JOINT_COUNT)
  ) watch (
    .clk          (clk),
    .rst          (rst),
    .cand_valid   (cand_valid),
    .cand_stall   (cand_stall),
    .cand         (cand),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .tol_we       (tol_we),
    .tol_data     (tol_data),
    .errors       (errors),
    .open_count   (open_count)
  );

  // result side: random hold-offs, and one long hold once armed so the block backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_armed && !hold_done) begin
      hold_left    <= 400;
      hold_done    <= 1'b1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic njs_pkg::cand_t make_item(input logic [1:0] func,
                                               input njs_pkg::joint_vec_t j,
                                               input njs_pkg::angle_t phi, input logic last);
    njs_pkg::cand_t c;
    c.func    = func;
    c.joint_0 = j[0];
    c.joint_1 = j[1];
    c.joint_2 = j[2];
    c.joint_3 = j[3];
    c.joint_4 = j[4];
    c.joint_5 = j[5];
    c.joint_6 = j[6];
    c.phi     = phi;
    c.last    = last;
    return c;
  endfunction

  function automatic njs_pkg::angle_t near(input njs_pkg::angle_t base, input int spread);
    int w;
    w = (1 << spread) - 1;
    return njs_pkg::angle_t'(int'(base) + int'($urandom_range(0, 2 * w)) - w);
  endfunction

  function automatic njs_pkg::angle_t pick_phi();
    case ($urandom_range(0, 5))
      0:       return ANGLE_MIN;
      1:       return ANGLE_MAX;
      2:       return njs_pkg::angle_t'(0);
      3, 4:    return near(njs_pkg::angle_t'(0), $urandom_range(1, 8));
      default: return njs_pkg::angle_t'($urandom);
    endcase
  endfunction

  function automatic njs_pkg::joint_vec_t wild_vec();
    njs_pkg::joint_vec_t v;
    for (int i = 0; i < njs_pkg::JOINT_FIELDS; i++) begin
      case ($urandom_range(0, 7))
        0:       v[i] = ANGLE_MIN;
        1:       v[i] = ANGLE_MAX;
        default: v[i] = njs_pkg::angle_t'($urandom);
      endcase
    end
    return v;
  endfunction

  // present one item, with random idle cycles ahead of it, and wait for it to be taken
  task automatic offer(input njs_pkg::cand_t c);
    while (!calm && $urandom_range(0, 99) < 26) begin
      cand_valid <= 1'b0;
      @(posedge clk);
    end
    cand_valid <= 1'b1;
    cand       <= c;
    @(posedge clk);
    while (cand_stall) @(posedge clk);
    if (c.func == njs_pkg::FUNC_REF)
      home = {c.joint_6, c.joint_5, c.joint_4, c.joint_3, c.joint_2, c.joint_1, c.joint_0};
    if (c.func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic load_home();
    offer(make_item(njs_pkg::FUNC_REF, wild_vec(), njs_pkg::angle_t'($urandom),
                    1'($urandom)));
  endtask

  // candidates scattered round the reference; some repeat the last joints with a new phi
  task automatic search(input int n, input logic close);
    njs_pkg::joint_vec_t j;
    int                  spread;
    j = home;
    case ($urandom_range(0, 4))
      0:       spread = 1;
      1:       spread = 3;
      2:       spread = 5;
      3:       spread = 8;
      default: spread = 16;
    endcase
    for (int k = 0; k < n; k++) begin
      if (k == 0 || $urandom_range(0, 99) >= 20) begin
        for (int i = 0; i < njs_pkg::JOINT_FIELDS; i++) j[i] = near(home[i], spread);
      end
      offer(make_item(njs_pkg::FUNC_CAND, j, pick_phi(), close && (k == n - 1)));
    end
  endtask

  task automatic churn(input int stop_at);
    int r;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        offer(make_item(2'($urandom_range(0, 3)), wild_vec(), njs_pkg::angle_t'($urandom),
                        1'($urandom)));
      end else if (r < 14) begin
        // unfinished search thrown away by an empty-search end
        search($urandom_range(0, 3), 1'b0);
        offer(make_item(njs_pkg::FUNC_END, wild_vec(), njs_pkg::angle_t'($urandom),
                        1'($urandom)));
      end else if (r < 20) begin
        // reference swapped part way through a search
        search($urandom_range(1, 3), 1'b0);
        load_home();
        search($urandom_range(1, 4), 1'b1);
      end else begin
        if ($urandom_range(0, 1) == 0) load_home();
        search($urandom_range(1, 6), 1'b1);
      end
    end
  endtask

  // let every due result drain, then wait on for items that give none
  task automatic settle();
    int waited;
    waited = 0;
    cand_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (24) @(posedge clk);
  endtask

  task automatic write_tol(input njs_pkg::tol_t v);
    tol_we   <= 1'b1;
    tol_data <= v;
    @(posedge clk);
    tol_we   <= 1'b0;
  endtask

  initial begin
    njs_pkg::joint_vec_t top_v;
    njs_pkg::joint_vec_t low_v;
    njs_pkg::joint_vec_t v;
    njs_pkg::tol_t       tol;
    top_v = {njs_pkg::JOINT_FIELDS{ANGLE_MAX}};
    low_v = {njs_pkg::JOINT_FIELDS{ANGLE_MIN}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // first candidate taken outright, even at the far corner
    offer(make_item(njs_pkg::FUNC_CAND, top_v, ANGLE_MIN, 1'b1));
    // reference load ignores its last bit
    offer(make_item(njs_pkg::FUNC_REF, low_v, ANGLE_MAX, 1'b1));
    offer(make_item(njs_pkg::FUNC_CAND, top_v, ANGLE_MIN, 1'b0));
    // exact tie, smaller |phi| takes over
    offer(make_item(njs_pkg::FUNC_CAND, top_v, ANGLE_MAX, 1'b0));
    offer(make_item(njs_pkg::FUNC_CAND, low_v, 16'sd5, 1'b0));
    // tie with equal |phi| keeps the old one
    offer(make_item(njs_pkg::FUNC_CAND, low_v, -16'sd5, 1'b0));
    // just outside the band and further away
    v    = low_v;
    v[3] = ANGLE_MIN + 16'sd41;
    offer(make_item(njs_pkg::FUNC_CAND, v, 16'sd0, 1'b1));
    offer(make_item(njs_pkg::FUNC_END, top_v, ANGLE_MAX, 1'b1));
    offer(make_item(FUNC_UNUSED, wild_vec(), njs_pkg::angle_t'($urandom), 1'b1));
    // empty-search end discards an open search
    offer(make_item(njs_pkg::FUNC_CAND, low_v, 16'sd7, 1'b0));
    offer(make_item(njs_pkg::FUNC_END, low_v, 16'sd0, 1'b0));
    v    = low_v;
    v[0] = ANGLE_MIN + 16'sd40;
    offer(make_item(njs_pkg::FUNC_CAND, v, 16'sd100, 1'b1));
    // reference reload in the middle of a search
    offer(make_item(njs_pkg::FUNC_CAND, '0, 16'sd3, 1'b0));
    offer(make_item(njs_pkg::FUNC_REF, '0, 16'sd0, 1'b0));
    offer(make_item(njs_pkg::FUNC_CAND, '0, 16'sd2, 1'b1));
    // ties inside the reset band around a non-zero best distance
    v    = '0;
    v[0] = 16'sd40;
    offer(make_item(njs_pkg::FUNC_CAND, v, 16'sd50, 1'b0));
    offer(make_item(njs_pkg::FUNC_CAND, '0, 16'sd60, 1'b0));
    v[0] = 16'sd57;
    offer(make_item(njs_pkg::FUNC_CAND, v, 16'sd10, 1'b1));
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       tol = '1;
        1:       tol = '0;
        2, 5:    tol = njs_pkg::tol_t'($urandom_range(0, 6000));
        4:       tol = njs_pkg::TOL_RESET;
        6:       tol = njs_pkg::tol_t'(1);
        default: tol = {3'($urandom), $urandom};
      endcase
      write_tol(tol);
      calm       <= (p == 3 || p == 5);
      hold_armed <= (p == 5);
      churn(items_sent + 160);
      settle();
    end

    if (errors == 0 && open_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/njs_pkg.sv
rtl/njs_front.sv
rtl/njs_queue.sv
rtl/njs_back.sv
rtl/nearest_joint_solution_phi_tiebreak.sv
rtl/njs_checker.sv
tb/sv/njs_result_checker.sv
tb/sv/tb_nearest_joint_solution_phi_tiebreak.sv
